@@ src/cprm_pkg.sv @@
package cprm_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned ActionW = 2;
  localparam int unsigned DivSteps = ScaleW;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  localparam logic [ActionW-1:0] ActCapture = 2'd0;
  localparam logic [ActionW-1:0] ActPeriod = 2'd1;
  localparam logic [ActionW-1:0] ActRpm = 2'd2;

  localparam logic [PeriodW-1:0] SatMax = 16'hFFFF;
  localparam logic [ScaleW-1:0] RpmScaleReset = 32'd4687500;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StOut  = 3'b100
  } state_e;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

@@ src/cprm_ctrl.sv @@
module cprm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  cprm_pkg::sts_t sts_i,
  output cprm_pkg::cmd_t cmd_o
);
  import cprm_pkg::*;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  state_e state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          cnt_d = '0;
          state_d = sts_i.need_div ? StDiv : StOut;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != StIdle))
    else $error("accepted item did not start processing");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StOut))
    else $error("result appeared outside the output step");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == DivLast) |=> (state_q == StOut))
    else $error("divider ran past its last step");

endmodule

@@ src/cprm_dp.sv @@
module cprm_dp #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cprm_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  logic [cprm_pkg::ActionW-1:0]   action_i,
  input  logic [cprm_pkg::PeriodW-1:0]   stamp_i,
  input  cprm_pkg::cmd_t                 cmd_i,
  output cprm_pkg::sts_t                 sts_o,
  output logic [cprm_pkg::PeriodW-1:0]   period_o,
  output logic [cprm_pkg::PeriodW-1:0]   speed_rpm_o,
  output logic [cprm_pkg::PeriodW-1:0]   shortest_o,
  output logic [cprm_pkg::PeriodW-1:0]   longest_o,
  output logic                           fresh_o
);
  import cprm_pkg::*;

  localparam int unsigned StampBits = (TIMER_BITS < PeriodW) ? TIMER_BITS : PeriodW;

  logic [ScaleW-1:0] scale_q;
  logic [StampBits-1:0] prev_q;
  logic have_prev_q;
  logic [PeriodW-1:0] latest_q;
  logic [PeriodW-1:0] min_q;
  logic [PeriodW-1:0] max_q;
  logic new_cap_q;
  logic was_fresh_q;
  logic [ActionW-1:0] act_q;

  logic [ScaleW-1:0] dvd_q;
  logic [PeriodW-1:0] rem_q;
  logic [PeriodW-1:0] divisor_q;

  logic [PeriodW-1:0] out_period_q, out_speed_q, out_min_q, out_max_q;
  logic out_fresh_q;

  logic [StampBits-1:0] stamp_diff;
  logic [PeriodW-1:0] new_period;
  logic [PeriodW:0] shifted;
  logic [PeriodW:0] trial;
  logic [PeriodW-1:0] speed_d;

  assign stamp_diff = stamp_i[StampBits-1:0] - prev_q;
  assign new_period = PeriodW'(stamp_diff);
  assign sts_o.need_div = (action_i == ActRpm) && new_cap_q && (latest_q != '0);

  assign shifted = {rem_q, dvd_q[ScaleW-1]};
  assign trial = shifted - {1'b0, divisor_q};

  always_comb begin
    speed_d = '0;
    if (act_q == ActRpm && was_fresh_q) begin
      if (latest_q == '0 || dvd_q[ScaleW-1:PeriodW] != '0) begin
        speed_d = SatMax;
      end else begin
        speed_d = dvd_q[PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= RpmScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      have_prev_q <= 1'b0;
      latest_q <= '0;
      min_q <= SatMax;
      max_q <= '0;
      new_cap_q <= 1'b0;
    end else if (cmd_i.load_item) begin
      case (action_i)
        ActCapture: begin
          latest_q <= new_period;
          if (have_prev_q) begin
            if (new_period > max_q) begin
              max_q <= new_period;
            end
            if (new_period < min_q) begin
              min_q <= new_period;
            end
          end
          prev_q <= stamp_i[StampBits-1:0];
          have_prev_q <= 1'b1;
          new_cap_q <= 1'b1;
        end
        ActPeriod, ActRpm: begin
          new_cap_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      was_fresh_q <= new_cap_q;
      act_q <= action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      divisor_q <= '0;
      dvd_q <= '0;
    end else if (cmd_i.load_item) begin
      rem_q <= '0;
      divisor_q <= latest_q;
      dvd_q <= scale_q;
    end else if (cmd_i.div_step) begin
      if (!trial[PeriodW]) begin
        rem_q <= trial[PeriodW-1:0];
      end else begin
        rem_q <= shifted[PeriodW-1:0];
      end
      dvd_q <= {dvd_q[ScaleW-2:0], ~trial[PeriodW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_period_q <= latest_q;
      out_speed_q <= speed_d;
      out_min_q <= min_q;
      out_max_q <= max_q;
      out_fresh_q <= was_fresh_q;
    end
  end

  assign period_o = out_period_q;
  assign speed_rpm_o = out_speed_q;
  assign shortest_o = out_min_q;
  assign longest_o = out_max_q;
  assign fresh_o = out_fresh_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (divisor_q != '0) |-> (rem_q < divisor_q))
    else $error("divider remainder reached the divisor");

endmodule

@@ src/capture_period_rpm_meter_core.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    action_i, stamp_i
// out       output     out_valid_o / out_stall_i  period_o, speed_rpm_o, shortest_o,
//                                                 longest_o, fresh_o
// cfg       input      cfg_we_i                   cfg_wdata_i (rpm scale)
//
// A capture, a period read, a stale rpm read or an rpm read of a zero period goes straight to its output step.
// Any other fresh rpm read first runs the divider, which retires one quotient bit per cycle.
// The reset is asynchronous and active low; the rpm scale resets to 4687500.
// A stalled result sits in the output register while the next item is taken in; that item
// then waits in its output step until the stall clears.
module capture_period_rpm_meter_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] stamp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] period_o,
  output logic [15:0] speed_rpm_o,
  output logic [15:0] shortest_o,
  output logic [15:0] longest_o,
  output logic        fresh_o
);
  import cprm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cprm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cprm_dp #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .stamp_i     (stamp_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .period_o    (period_o),
    .speed_rpm_o (speed_rpm_o),
    .shortest_o  (shortest_o),
    .longest_o   (longest_o),
    .fresh_o     (fresh_o)
  );

endmodule
